>>> rtl/nobd_pkg.sv
// Shared types and constants for the nth-order backward difference block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package nobd_pkg;

	// Field widths fixed by the block's interface
	localparam int SAMPLE_BITS   = 24;
	localparam int DIFF_BITS     = 41;
	localparam int CFG_BITS      = 5;

	// Order register width inside the block, wide enough for the largest order
	localparam int ORDER_BITS    = 8;

	// Default for the top-level order cap
	localparam int MAX_ORDER_DEF = 16;

	// Command queue between front and back
	localparam int QUEUE_DEPTH   = 4;

	// Request type codes
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// One classified request, as queued between front and back
	typedef struct packed {
		op_t                           op;
		logic signed [SAMPLE_BITS-1:0] sample;
	} item_t;

	// Order and history-clear strobe from the front to the back
	typedef struct packed {
		logic [ORDER_BITS-1:0] order;
		logic                  clear;
	} cfg_t;

endpackage

>>> rtl/nobd_if.sv
// Valid/ready channel interfaces for the sample input and the difference output.
// Depends on nobd_pkg for the field widths.
`timescale 1ns / 1ps

interface nobd_in_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    req_type;
	logic signed [nobd_pkg::SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output req_type, output sample_in, input ready);
	modport sink   (input valid, input req_type, input sample_in, output ready);
endinterface

interface nobd_out_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [nobd_pkg::DIFF_BITS-1:0] diff_out;
	logic                                  rising;

	modport source (output valid, output diff_out, output rising, input ready);
	modport sink   (input valid, input diff_out, input rising, output ready);
endinterface

>>> rtl/nobd_front.sv
// Front end: input beat register, request classification and the order register.
// Depends on nobd_pkg and nobd_in_if.
`timescale 1ns / 1ps

module nobd_front #(
	parameter int MAX_ORDER = nobd_pkg::MAX_ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nobd_in_if.sink                       in,
	input  logic                          cfg_we,
	input  logic [nobd_pkg::CFG_BITS-1:0] cfg_wdata,
	output logic                          f_valid,
	output nobd_pkg::item_t               f_item,
	input  logic                          f_ready,
	output nobd_pkg::cfg_t                cfg
);

	logic                              vld_s1;
	nobd_pkg::item_t                   item_s1;
	logic [nobd_pkg::ORDER_BITS-1:0]   order_q;
	logic                              clear_q;
	logic [nobd_pkg::ORDER_BITS-1:0]   wr_order;

	// Clamp the written order into 1..MAX_ORDER
	always_comb begin
		if (cfg_wdata == '0) begin
			wr_order = nobd_pkg::ORDER_BITS'(1);
		end else if (nobd_pkg::ORDER_BITS'(cfg_wdata) > nobd_pkg::ORDER_BITS'(MAX_ORDER)) begin
			wr_order = nobd_pkg::ORDER_BITS'(MAX_ORDER);
		end else begin
			wr_order = nobd_pkg::ORDER_BITS'(cfg_wdata);
		end
	end

	// Hold the order; strobe a history clear when it changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= nobd_pkg::ORDER_BITS'(1);
			clear_q <= 1'b0;
		end else begin
			clear_q <= cfg_we && (wr_order != order_q);
			if (cfg_we) begin
				order_q <= wr_order;
			end
		end
	end

	assign cfg.order = order_q;
	assign cfg.clear = clear_q;

	// Take a beat whenever the register is empty or drains this cycle
	assign in.ready = !vld_s1 || f_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in.ready) begin
			vld_s1 <= in.valid;
		end
	end

	// Classify the beat into a queue entry
	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			item_s1.op     <= in.req_type ? nobd_pkg::OP_CLEAR : nobd_pkg::OP_SAMPLE;
			item_s1.sample <= in.sample_in;
		end
	end

	assign f_valid = vld_s1;
	assign f_item  = item_s1;

endmodule

>>> rtl/nobd_queue.sv
// Short command queue that decouples the front end from the difference pipeline.
// Depends on nobd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module nobd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  nobd_pkg::item_t push_item,
	output logic            push_ready,
	output logic            pop_valid,
	output nobd_pkg::item_t pop_item,
	input  logic            pop
);

	localparam int DEPTH = nobd_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	nobd_pkg::item_t entry_q [0:DEPTH-1];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;
	logic            push;

	assign push_ready = (count_q != (AW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/nobd_back.sv
// Back end: cascade of first-difference stages, one per order, and the output register.
// Depends on nobd_pkg and nobd_out_if.
`timescale 1ns / 1ps

module nobd_back #(
	parameter int MAX_ORDER = nobd_pkg::MAX_ORDER_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  nobd_pkg::item_t q_item,
	output logic            q_pop,
	input  nobd_pkg::cfg_t  cfg,
	nobd_out_if.source      out
);

	// Order k difference of SAMPLE_BITS samples needs SAMPLE_BITS + k + 1 bits
	localparam int DW = nobd_pkg::SAMPLE_BITS + MAX_ORDER + 1;
	localparam int SB = nobd_pkg::SAMPLE_BITS;

	logic [MAX_ORDER:0]     vld_s;
	nobd_pkg::op_t          op_s   [0:MAX_ORDER];
	logic signed [DW-1:0]   val_s  [0:MAX_ORDER];
	logic signed [DW-1:0]   prev_q [1:MAX_ORDER];
	logic                   out_vld_q;
	logic signed [nobd_pkg::DIFF_BITS-1:0] diff_q;
	logic                   rising_q;
	logic                   adv;
	logic signed [DW-1:0]   fin;

	// The whole pipeline moves when the output register can take a beat;
	// hold it for the cycle in which the history is wiped
	assign adv   = (!out_vld_q || out.ready) && !cfg.clear;
	assign q_pop = adv && q_valid;
	assign fin   = val_s[MAX_ORDER];

	// Valid bits and per-stage history (previous lower-order difference)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
			for (int k = 1; k <= MAX_ORDER; k++) begin
				prev_q[k] <= '0;
			end
		end else if (cfg.clear) begin
			for (int k = 1; k <= MAX_ORDER; k++) begin
				prev_q[k] <= '0;
			end
		end else if (adv) begin
			vld_s[0] <= q_valid;
			for (int k = 1; k <= MAX_ORDER; k++) begin
				vld_s[k] <= vld_s[k-1];
				if (vld_s[k-1]) begin
					if (op_s[k-1] == nobd_pkg::OP_CLEAR) begin
						prev_q[k] <= '0;
					end else begin
						prev_q[k] <= val_s[k-1];
					end
				end
			end
			out_vld_q <= vld_s[MAX_ORDER] && (op_s[MAX_ORDER] == nobd_pkg::OP_SAMPLE);
		end
	end

	// Difference stages: stage k subtracts the previous beat's value when k <= order
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[0]  <= q_item.op;
			val_s[0] <= {{(DW-SB){q_item.sample[SB-1]}}, q_item.sample};
			for (int k = 1; k <= MAX_ORDER; k++) begin
				op_s[k] <= op_s[k-1];
				if (k <= int'(cfg.order)) begin
					val_s[k] <= val_s[k-1] - prev_q[k];
				end else begin
					val_s[k] <= val_s[k-1];
				end
			end
			diff_q   <= nobd_pkg::DIFF_BITS'(fin);
			rising_q <= !fin[DW-1];
		end
	end

	assign out.valid    = out_vld_q;
	assign out.diff_out = diff_q;
	assign out.rising   = rising_q;

endmodule

>>> rtl/nth_order_backward_difference.sv
// Top level of the nth-order backward difference block: front, queue, back.
// Depends on nobd_pkg, nobd_if, nobd_front, nobd_queue and nobd_back.
//
//  channel   direction  payload                    handshake
//  in        sink       req_type, sample_in        valid/ready
//  out       source     diff_out, rising           valid/ready
//  cfg       write      cfg_wdata (diff_order)     cfg_we
//
// One beat per cycle in and out when neither side stalls and no order change
// wipes the history; a sample passes through the input register, the queue,
// the entry stage, MAX_ORDER difference stages and the output register.
// arst_n clears the order to 1, all difference history and all valid bits.
// An output stall freezes the back pipeline; the queue and the input register
// keep taking beats until they fill.
`timescale 1ns / 1ps

module nth_order_backward_difference #(
	parameter int MAX_ORDER = nobd_pkg::MAX_ORDER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nobd_in_if.sink                       in,
	nobd_out_if.source                    out,
	input  logic                          cfg_we,
	input  logic [nobd_pkg::CFG_BITS-1:0] cfg_wdata
);

	logic            f_valid;
	nobd_pkg::item_t f_item;
	logic            f_ready;
	logic            q_valid;
	nobd_pkg::item_t q_item;
	logic            q_pop;
	nobd_pkg::cfg_t  cfg;

	nobd_front #(
		.MAX_ORDER (MAX_ORDER)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.f_valid   (f_valid),
		.f_item    (f_item),
		.f_ready   (f_ready),
		.cfg       (cfg)
	);

	nobd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	nobd_back #(
		.MAX_ORDER (MAX_ORDER)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.cfg     (cfg),
		.out     (out)
	);

`ifndef NO_ASSERTIONS
	// The back never pops an empty queue
	a_pop_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// The order in force stays within 1..MAX_ORDER
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.order >= nobd_pkg::ORDER_BITS'(1)) &&
		(cfg.order <= nobd_pkg::ORDER_BITS'(MAX_ORDER)))
		else $error("order out of range");

	// A front beat refused by a full queue is held, not dropped
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid && (f_item == $past(f_item)))
		else $error("front beat lost while queue full");
`endif

endmodule
